@@ hdl/cln_pkg.sv @@
package cln_pkg;

   localparam logic [1:0] ACT_INIT = 2'd0;
   localparam logic [1:0] ACT_CMD  = 2'd1;
   localparam logic [1:0] ACT_TEXT = 2'd2;

   localparam logic [1:0] CSR_NIBBLE_GAP = 2'd0;
   localparam logic [1:0] CSR_CHAR_GAP   = 2'd1;
   localparam logic [1:0] CSR_LINE_LEN   = 2'd2;
   localparam logic [1:0] CSR_WRAP_CMD   = 2'd3;

   localparam logic [6:0] COUNT_MAX  = 7'd127;
   localparam logic [3:0] INIT_FINAL = 4'd15;

   localparam logic [15:0] RST_NIBBLE_GAP = 16'd30000;
   localparam logic [15:0] RST_CHAR_GAP   = 16'd800;
   localparam logic [6:0]  RST_LINE_LEN   = 7'd16;
   localparam logic [7:0]  RST_WRAP_CMD   = 8'hc0;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_value;
      logic       new_string;
   } req_type;

   typedef struct packed {
      logic [3:0]  nibble;
      logic        register_select;
      logic [16:0] wait_ticks;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] nibble_gap_ticks;
      logic [15:0] char_gap_ticks;
      logic [6:0]  line_length;
      logic [7:0]  wrap_command;
   } cfg_type;

   // one queued job: init sequence, or one byte with an optional wrap command after it
   typedef struct packed {
      logic       is_init;
      logic [7:0] byte_value;
      logic       rs;
      logic       char_gap;
      logic       wrap;
   } job_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   function automatic logic [7:0] init_cmd(input logic [2:0] idx);
      logic [7:0] r;
      unique case (idx)
         3'd0, 3'd1, 3'd2: r = 8'h30;
         3'd3:             r = 8'h20;
         3'd4:             r = 8'h28;
         3'd5:             r = 8'h0c;
         3'd6:             r = 8'h06;
         default:          r = 8'h01;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] init_settle(input logic [2:0] idx);
      logic [15:0] r;
      unique case (idx)
         3'd0:    r = 16'd800;
         3'd7:    r = 16'd2000;
         default: r = 16'd200;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/cln_front.sv @@
module cln_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cln_pkg::req_type req_data,
   input  logic [6:0]       line_length,
   input  logic             q_full,
   output logic             q_push,
   output cln_pkg::job_type q_job
);
   import cln_pkg::*;

   logic [6:0] cnt_ff;
   logic [6:0] cnt_in;
   logic [6:0] base;
   logic       inc;
   logic       accept;
   logic       is_text;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_text   = (req_data.action == ACT_TEXT);

   always_comb begin
      base = req_data.new_string ? 7'd0 : cnt_ff;
      inc  = (base != COUNT_MAX);
      cnt_in = cnt_ff;
      if (accept && is_text) begin
         cnt_in = inc ? base + 7'd1 : base;
      end
   end

   always_comb begin
      q_job.is_init    = (req_data.action == ACT_INIT);
      q_job.byte_value = req_data.byte_value;
      q_job.rs         = is_text;
      q_job.char_gap   = is_text;
      q_job.wrap       = is_text && inc && ((base + 7'd1) == line_length);
      // unused action code is dropped here
      q_push = accept && (req_data.action == ACT_INIT || req_data.action == ACT_CMD ||
                          req_data.action == ACT_TEXT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 7'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/cln_queue.sv @@
module cln_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cln_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output cln_pkg::job_type pop_data,
   output logic             empty
);
   import cln_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ff;
   logic       wr_in;
   logic       rd_ff;
   logic       rd_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/cln_back.sv @@
module cln_back #(
   parameter int WAIT_WIDTH = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  cln_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  cln_pkg::job_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cln_pkg::rsp_type rsp_data
);
   import cln_pkg::*;

   localparam logic [32:0] WAIT_LIMIT = (33'd1 << WAIT_WIDTH) - 33'd1;

   back_state_type state_ff;
   back_state_type state_in;
   job_type        job_ff;
   job_type        job_in;
   logic [3:0]     step_ff;
   logic [3:0]     step_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_data_ff;
   rsp_type        rsp_data_in;

   logic        adv;
   logic        strobe_last;
   logic [7:0]  cur_byte;
   logic [15:0] extra;
   logic [16:0] sum;
   logic [32:0] sat;
   rsp_type     strobe;

   // strobe for this step: in byte jobs 0,1 are the byte, 2,3 the wrap command
   always_comb begin
      if (job_ff.is_init) begin
         cur_byte = init_cmd(step_ff[3:1]);
      end else if (step_ff[1]) begin
         cur_byte = cfg.wrap_command;
      end else begin
         cur_byte = job_ff.byte_value;
      end

      if (!step_ff[0]) begin
         extra = 16'd0;
      end else if (job_ff.is_init) begin
         extra = init_settle(step_ff[3:1]);
      end else if (step_ff[1] || job_ff.char_gap) begin
         extra = cfg.char_gap_ticks;
      end else begin
         extra = 16'd0;
      end

      sum = {1'b0, cfg.nibble_gap_ticks} + {1'b0, extra};
      sat = (33'(sum) > WAIT_LIMIT) ? WAIT_LIMIT : 33'(sum);

      if (job_ff.is_init) begin
         strobe_last = (step_ff == INIT_FINAL);
      end else begin
         strobe_last = step_ff[0] && (step_ff[1] || !job_ff.wrap);
      end

      strobe.nibble          = step_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
      strobe.register_select = !job_ff.is_init && !step_ff[1] && job_ff.rs;
      strobe.wait_ticks      = sat[16:0];
      strobe.last            = strobe_last;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) state_in = BK_RUN;
         end
         BK_RUN: begin
            if (adv && strobe_last && q_empty) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      adv   = (state_ff == BK_RUN) && (!rsp_valid_ff || !rsp_stall);
      q_pop = !q_empty && ((state_ff == BK_IDLE) || (adv && strobe_last));

      job_in  = q_pop ? q_data : job_ff;
      step_in = q_pop ? 4'd0 : (adv ? step_ff + 4'd1 : step_ff);

      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_data_in = adv ? strobe : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty job queue");

   a_byte_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_RUN && !job_ff.is_init) |-> (step_ff < 4'd4))
      else $error("byte job ran past its wrap strobes");

   a_no_wrap_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_RUN && !job_ff.is_init && !job_ff.wrap) |-> (step_ff < 4'd2))
      else $error("byte job without wrap ran past two strobes");

   a_adv_sets_valid: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid_ff)
      else $error("generated strobe not presented");

endmodule

@@ hdl/char_lcd_nibble_writer.sv @@
// path: req -> job queue -> back job register -> registered strobe on rsp
// throughput: one strobe per cycle from the back sequencer while rsp is not stalled; an item
// takes 2 strobes (command or text), 4 (text with wrap command) or 16 (init), a two-entry job
// queue lets the front take new items while the back still works
// reset: synchronous active high; clears the character counter, queue, sequencer state and
// output valid, and loads the register defaults
module char_lcd_nibble_writer #(
   parameter int WAIT_WIDTH = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cln_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cln_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import cln_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    q_push;
   job_type q_job;
   logic    q_full;
   logic    q_pop;
   job_type q_data;
   logic    q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NIBBLE_GAP: cfg_in.nibble_gap_ticks = csr_wdata;
            CSR_CHAR_GAP:   cfg_in.char_gap_ticks   = csr_wdata;
            CSR_LINE_LEN:   cfg_in.line_length      = csr_wdata[6:0];
            CSR_WRAP_CMD:   cfg_in.wrap_command     = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nibble_gap_ticks <= RST_NIBBLE_GAP;
         cfg_ff.char_gap_ticks   <= RST_CHAR_GAP;
         cfg_ff.line_length      <= RST_LINE_LEN;
         cfg_ff.wrap_command     <= RST_WRAP_CMD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cln_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .line_length (cfg_ff.line_length),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_job)
   );

   cln_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   cln_back #(
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
